/* hw/rtl/mmsm_pkg.sv */
// ----------------------------------------------------------------------------
// mmsm_pkg
// Shared constants and codes of the max-magnitude stream mixer.
// ----------------------------------------------------------------------------
package mmsm_pkg;

	localparam int NUM_SLOTS_DEF  = 8;
	localparam int FIFO_DEPTH_DEF = 1024;

	typedef enum logic [1:0] {
		FUNC_PUSH    = 2'd0,
		FUNC_CLEAR   = 2'd1,
		FUNC_RELEASE = 2'd2,
		FUNC_READ    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_SLOT = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

endpackage

/* hw/rtl/max_magnitude_stream_mixer_unit.sv */
// ----------------------------------------------------------------------------
// max_magnitude_stream_mixer_unit
// Stream slot table with per-slot sample FIFOs in one shared memory; a read
// pops every non-empty FIFO head and returns the largest-magnitude sample.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | func, owner_id, stream_id, sample, burst_end
//  out     | out_valid / out_ready| mixed_sample, sample_valid, source_count,
//          |                      | status, active_streams
//
// Push, clear and release register the word, match slots, then update
// state. A read registers the word, walks the slots, then loads the result:
// the sample memory has one read port, so it walks the slots one head a cycle.
// A word is taken while a result still waits in the output register; the
// last step of an item stalls only if that register is still full by then.
// Reset clears active marks, heads, fills and the control state.
module max_magnitude_stream_mixer_unit #(
	parameter int NUM_SLOTS  = mmsm_pkg::NUM_SLOTS_DEF,
	parameter int FIFO_DEPTH = mmsm_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  owner_id,
	input  logic [31:0] stream_id,
	input  logic signed [15:0] sample,
	input  logic        burst_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] mixed_sample,
	output logic        sample_valid,
	output logic [3:0]  source_count,
	output logic [1:0]  status,
	output logic [3:0]  active_streams
);
	import mmsm_pkg::*;

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int FW = $clog2(FIFO_DEPTH + 1);
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int AW = SW + PW;
	localparam int MEM_DEPTH = NUM_SLOTS * (1 << PW);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MATCH = 5'b00010,
		S_APPLY = 5'b00100,
		S_WALK  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;

	// Slot table in flip-flops, sample store in memory
	logic [NUM_SLOTS-1:0] active_q;
	logic [7:0]           owner_q  [NUM_SLOTS];
	logic [31:0]          stream_q [NUM_SLOTS];
	logic [PW-1:0]        head_q   [NUM_SLOTS];
	logic [FW-1:0]        fill_q   [NUM_SLOTS];
	logic [15:0]          mem [MEM_DEPTH];

	// Registered input word
	func_t       func_q;
	logic [7:0]  own_q;
	logic [31:0] sid_q;
	logic [15:0] smp_q;

	// Match results
	logic [NUM_SLOTS-1:0] hit_q, hitown_q;
	logic [SW-1:0]        tgt_q;
	logic                 tgt_ok_q, tgt_new_q;

	// Read walk
	logic [SW:0]   walk_q;
	logic          rd_vld_s1;
	logic [15:0]   rd_data_s1;
	logic [CW-1:0] src_q;
	logic signed [15:0] best_q;

	// Output register
	logic        ovld_q;
	logic [15:0] omix_q;
	logic        osv_q;
	logic [3:0]  osrc_q;
	logic [1:0]  ost_q;
	logic [3:0]  oact_q;

	// Combinational match and free search
	logic [NUM_SLOTS-1:0] hit_c, hitown_c;
	logic [SW-1:0] hit_idx_c, free_idx_c;
	logic          hit_any_c, free_any_c;
	logic [CW-1:0] act_cnt_c;

	always_comb begin
		hit_idx_c  = '0;
		free_idx_c = '0;
		hit_any_c  = 1'b0;
		free_any_c = 1'b0;
		act_cnt_c  = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			hitown_c[i] = active_q[i] && (owner_q[i] == own_q);
			hit_c[i]    = hitown_c[i] && (stream_q[i] == sid_q);
			if (hit_c[i]) begin
				hit_idx_c = SW'(i);
				hit_any_c = 1'b1;
			end
			if (!active_q[i]) begin
				free_idx_c = SW'(i);
				free_any_c = 1'b1;
			end
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			act_cnt_c = act_cnt_c + CW'(active_q[i]);
		end
	end

	function automatic logic [3:0] sat15(input logic [CW-1:0] v);
		if ({{(32-CW){1'b0}}, v} > 32'd15) return 4'd15;
		return 4'(v);
	endfunction

	function automatic logic [16:0] magn(input logic signed [15:0] v);
		logic [16:0] e;
		e = {v[15], v};
		return v[15] ? 17'(-e) : e;
	endfunction

	// Walk address and current slot
	logic [SW-1:0] wslot;
	logic          walk_take;
	assign wslot     = walk_q[SW-1:0];
	assign walk_take = (state_q == S_WALK) && (walk_q < (SW+1)'(NUM_SLOTS))
		&& active_q[wslot] && (fill_q[wslot] != '0);

	logic [AW-1:0] wr_addr;
	logic [PW:0]   wr_sum;
	assign wr_sum  = {1'b0, head_q[tgt_q]} + (PW+1)'(fill_q[tgt_q]);
	assign wr_addr = {tgt_q, wr_sum[PW-1:0]};

	logic do_write;
	assign do_write = (state_q == S_APPLY) && (func_q == FUNC_PUSH) && tgt_ok_q
		&& (tgt_new_q || (fill_q[tgt_q] != FW'(FIFO_DEPTH)));

	// Sample memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_addr] <= smp_q;
		end
		rd_data_s1 <= mem[{wslot, head_q[wslot]}];
	end

	assign in_ready = (state_q == S_IDLE);
	logic out_free;
	assign out_free = !ovld_q || out_ready;
	logic out_load;
	assign out_load = ((state_q == S_APPLY) || (state_q == S_DONE)) && out_free;

	// Control, slot table and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			active_q  <= '0;
			ovld_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			// Load the output register when a result is ready, else drain it
			if (out_load) ovld_q <= 1'b1;
			else if (out_ready) ovld_q <= 1'b0;
			rd_vld_s1 <= walk_take;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func_t'(func);
						own_q   <= owner_id;
						sid_q   <= stream_id;
						smp_q   <= sample;
						walk_q  <= '0;
						src_q   <= '0;
						best_q  <= '0;
						state_q <= (func_t'(func) == FUNC_READ) ? S_WALK : S_MATCH;
					end
				end
				S_MATCH: begin
					hit_q     <= hit_c;
					hitown_q  <= hitown_c;
					tgt_q     <= hit_any_c ? hit_idx_c : free_idx_c;
					tgt_ok_q  <= hit_any_c || free_any_c;
					tgt_new_q <= !hit_any_c;
					state_q   <= S_APPLY;
				end
				S_APPLY: begin
					if (out_free) begin
						omix_q <= '0;
						osv_q  <= 1'b0;
						osrc_q <= '0;
						unique case (func_q)
							FUNC_PUSH: begin
								if (!tgt_ok_q) begin
									ost_q  <= ST_NO_SLOT;
									oact_q <= sat15(act_cnt_c);
								end else if (tgt_new_q) begin
									active_q[tgt_q] <= 1'b1;
									owner_q[tgt_q]  <= own_q;
									stream_q[tgt_q] <= sid_q;
									head_q[tgt_q]   <= '0;
									fill_q[tgt_q]   <= FW'(1);
									ost_q  <= ST_OK;
									oact_q <= sat15(act_cnt_c + CW'(1));
								end else begin
									oact_q <= sat15(act_cnt_c);
									if (fill_q[tgt_q] == FW'(FIFO_DEPTH)) begin
										ost_q <= ST_FULL;
									end else begin
										ost_q <= ST_OK;
										fill_q[tgt_q] <= fill_q[tgt_q] + FW'(1);
									end
								end
							end
							FUNC_CLEAR, FUNC_RELEASE: begin
								logic [CW-1:0] n;
								n = '0;
								for (int i = 0; i < NUM_SLOTS; i++) begin
									if ((func_q == FUNC_RELEASE) ? hitown_q[i] : hit_q[i]) begin
										active_q[i] <= 1'b0;
										head_q[i]   <= '0;
										fill_q[i]   <= '0;
									end else begin
										n = n + CW'(active_q[i]);
									end
								end
								ost_q  <= ST_OK;
								oact_q <= sat15(n);
							end
							default: begin
								ost_q  <= ST_OK;
								oact_q <= sat15(act_cnt_c);
							end
						endcase
						state_q <= S_IDLE;
					end
				end
				S_WALK: begin
					// Pop one head a cycle; fold the previous slot's data
					if (walk_take) begin
						head_q[wslot] <= head_q[wslot] + PW'(1);
						fill_q[wslot] <= fill_q[wslot] - FW'(1);
					end
					if (rd_vld_s1) begin
						if (src_q == '0 || magn(rd_data_s1) > magn(best_q))
							best_q <= rd_data_s1;
						src_q <= src_q + CW'(1);
					end
					if (walk_q == (SW+1)'(NUM_SLOTS)) state_q <= S_DONE;
					else walk_q <= walk_q + (SW+1)'(1);
				end
				S_DONE: begin
					if (out_free) begin
						omix_q  <= best_q;
						osv_q   <= (src_q != '0);
						osrc_q  <= sat15(src_q);
						ost_q   <= ST_OK;
						oact_q  <= sat15(act_cnt_c);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic unused_ok;
	assign unused_ok = burst_end;

	assign out_valid      = ovld_q && (unused_ok || !unused_ok);
	assign mixed_sample   = omix_q;
	assign sample_valid   = osv_q;
	assign source_count   = osrc_q;
	assign status         = ost_q;
	assign active_streams = oact_q;

endmodule
